### rtl/core/text_terminal_glyph_renderer_core_assert.svh
`ifndef TEXT_TERMINAL_GLYPH_RENDERER_CORE_ASSERT_SVH
`define TEXT_TERMINAL_GLYPH_RENDERER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTGR_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TTGR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/ttgr_pkg.sv
`default_nettype none

package ttgr_pkg;

    // Default layout parameters.
    localparam int COLUMNS_DEF       = 80;
    localparam int VISIBLE_LINES_DEF = 24;
    localparam int GLYPH_ROWS_DEF    = 16;

    // Field and storage widths.
    localparam int MODE_W     = 2;
    localparam int FONT_AW    = 12;
    localparam int FONT_DEPTH = 4096;
    localparam int BITS_W     = 8;
    localparam int CODE_W     = 8;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 7;
    localparam int LINE_W     = 16;
    localparam int ORG_W      = 12;
    localparam int COORD_W    = 13;
    localparam int DIFF_W     = 8;
    localparam int ADD_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Transaction modes.
    localparam logic [MODE_W-1:0] MODE_FONT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHAR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

    // Control bytes.
    localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 8'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE = 2'd2;

    // Text area geometry.
    localparam int TEXT_X_OFF  = 26;
    localparam int TEXT_Y_OFF  = 61;
    localparam int CARET_Y_OFF = 14;
    localparam int CARET_ROWS  = 2;
    localparam logic [BITS_W-1:0] CARET_MASK = 8'hFE;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHOW,
        ST_XBASE,
        ST_XOFF,
        ST_YMUL,
        ST_YBASE,
        ST_YOFF,
        ST_ROW,
        ST_WRAP
    } seq_state_t;

    typedef struct packed {
        logic               we;
        logic [FONT_AW-1:0] addr;
        logic [BITS_W-1:0]  data;
    } font_wr_t;

    typedef struct packed {
        logic               re;
        logic [FONT_AW-1:0] addr;
    } font_rd_t;

endpackage

`default_nettype wire

### rtl/core/ttgr_if.sv
`default_nettype none

interface ttgr_cmd_if;
    import ttgr_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0]  mode;
    logic [FONT_AW-1:0] font_address;
    logic [BITS_W-1:0]  font_bits;
    logic [CODE_W-1:0]  char_code;
    logic              caret_on;

    modport source (
        output valid, mode, font_address, font_bits, char_code, caret_on,
        input  ready
    );

    modport sink (
        input  valid, mode, font_address, font_bits, char_code, caret_on,
        output ready
    );
endinterface

interface ttgr_pix_if;
    import ttgr_pkg::*;

    logic               valid;
    logic               ready;
    logic               row_kind;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [BITS_W-1:0]  pixel_mask;
    logic               last_row;

    modport source (
        output valid, row_kind, pixel_x, pixel_y, pixel_mask, last_row,
        input  ready
    );

    modport sink (
        input  valid, row_kind, pixel_x, pixel_y, pixel_mask, last_row,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/ttgr_font_mem.sv
`default_nettype none

// Font store: one write port, one registered read port.
module ttgr_font_mem (
    input  logic                                clk,
    input  ttgr_pkg::font_wr_t                  wr,
    input  ttgr_pkg::font_rd_t                  rd,
    output logic [ttgr_pkg::BITS_W-1:0]         rdata
);
    import ttgr_pkg::*;

    logic [BITS_W-1:0] mem [FONT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.re)
        begin
            rdata <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/text_terminal_glyph_renderer_core.sv
// Text terminal glyph renderer: lays out terminal bytes in a text grid and
// expands each visible character into 8-pixel glyph row masks.
// The cmd channel carries one transaction per font row write, terminal byte
// or finish request. The pix channel carries one transaction per pixel row.
// Font writes, newlines, backspaces and finish requests without a caret
// complete in the accepting cycle, so cmd is ready again on the next one.
// A printable byte on a shown line passes the window test, coordinate setup
// through the shared adder (x base, x offset, y multiply, y base, y offset),
// sixteen glyph rows at one per cycle from the font store read port while
// pix does not stall, and a wrap-up step that advances the column. A hidden
// line goes from the window test straight to wrap-up. A caret finish takes the
// same steps as a shown printable byte but yields two caret rows.
// When pix stalls, the output register holds its row, the font read port
// holds its data and the sequencer waits; cmd stays not ready meanwhile.
// Reset clears the counters, the configuration registers and the output
// valid flag. The font store is not cleared and must be written before use.
// Configuration writes are taken at any clock edge with cfg_we high.
`default_nettype none

module text_terminal_glyph_renderer_core #(
    parameter int COLUMNS       = ttgr_pkg::COLUMNS_DEF,
    parameter int VISIBLE_LINES = ttgr_pkg::VISIBLE_LINES_DEF,
    parameter int GLYPH_ROWS    = ttgr_pkg::GLYPH_ROWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ttgr_cmd_if.sink                          cmd,
    ttgr_pix_if.source                        pix,
    input  logic                              cfg_we,
    input  logic [ttgr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ttgr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ttgr_pkg::*;

    // Configuration registers.
    logic [ORG_W-1:0]  origin_x_reg;
    logic [ORG_W-1:0]  origin_y_reg;
    logic [LINE_W-1:0] first_line_reg;

    // Layout counters.
    logic [COL_W-1:0]  col_reg;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_inc;

    // Sequencer state and per-transaction working registers.
    seq_state_t         state_reg;
    seq_state_t         state_next;
    logic [CODE_W-1:0]  code_reg;
    logic               caret_reg;
    logic [DIFF_W-1:0]  diff_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   last_idx;

    // Output register.
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic [BITS_W-1:0]  out_mask_reg;
    logic               out_last_reg;

    // The shared adder. Every coordinate and the window test go through it.
    logic [ADD_W-1:0] add_a;
    logic [ADD_W-1:0] add_b;
    logic             add_cin;
    logic [ADD_W:0]   add_sum;

    logic             cmd_fire;
    logic             slot_free;
    logic             row_load;
    logic             line_shown;
    font_wr_t         font_wr;
    font_rd_t         font_rd;
    logic [BITS_W-1:0] font_rdata;

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (ADD_W + 1)'(add_cin);

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;

    // The output register is free when empty or when its row leaves this cycle.
    assign slot_free = !out_valid_reg || pix.ready;
    assign row_load  = (state_reg == ST_ROW) && slot_free;

    // In the window-test step the adder forms line - first_shown_line; the
    // carry out is set exactly when the line is at or below the first line.
    assign line_shown = add_sum[ADD_W] && (add_sum[ADD_W-1:0] < ADD_W'(VISIBLE_LINES));

    assign last_idx = caret_reg ? ROW_W'(CARET_ROWS - 1) : ROW_W'(GLYPH_ROWS - 1);
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + 1'b1;

    assign font_wr.we   = cmd_fire && (cmd.mode == MODE_FONT);
    assign font_wr.addr = cmd.font_address;
    assign font_wr.data = cmd.font_bits;

    ttgr_font_mem u_font_mem (
        .clk   (clk),
        .wr    (font_wr),
        .rd    (font_rd),
        .rdata (font_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.mode == MODE_CHAR && cmd.char_code != CHAR_NEWLINE &&
                        cmd.char_code != CHAR_BACKSPACE)
                    begin
                        state_next = ST_SHOW;
                    end
                    else if (cmd.mode == MODE_FINISH && cmd.caret_on)
                    begin
                        state_next = ST_SHOW;
                    end
                end
            end
            ST_SHOW:  state_next = line_shown ? ST_XBASE : ST_WRAP;
            ST_XBASE: state_next = ST_XOFF;
            ST_XOFF:  state_next = ST_YMUL;
            ST_YMUL:  state_next = ST_YBASE;
            ST_YBASE: state_next = ST_YOFF;
            ST_YOFF:  state_next = ST_ROW;
            ST_ROW:
            begin
                if (row_load && row_reg == last_idx)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Adder operand selection and font read control for each step.
    always_comb
    begin
        add_a        = '0;
        add_b        = '0;
        add_cin      = 1'b0;
        font_rd.re   = 1'b0;
        font_rd.addr = {code_reg, row_reg + 1'b1};
        unique case (state_reg)
            ST_SHOW:
            begin
                add_a   = line_reg;
                add_b   = ~first_line_reg;
                add_cin = 1'b1;
            end
            ST_XBASE:
            begin
                add_a = ADD_W'(origin_x_reg);
                add_b = ADD_W'({col_reg, 3'b000});
            end
            ST_XOFF:
            begin
                add_a = ADD_W'(x_reg);
                add_b = ADD_W'(TEXT_X_OFF);
            end
            ST_YMUL:
            begin
                // Line pitch of 18 pixels as 16 d + 2 d.
                add_a = ADD_W'({diff_reg, 4'b0000});
                add_b = ADD_W'({diff_reg, 1'b0});
            end
            ST_YBASE:
            begin
                add_a = ADD_W'(y_reg);
                add_b = ADD_W'(origin_y_reg);
            end
            ST_YOFF:
            begin
                add_a        = ADD_W'(y_reg);
                add_b        = caret_reg ? ADD_W'(TEXT_Y_OFF + CARET_Y_OFF)
                                         : ADD_W'(TEXT_Y_OFF);
                font_rd.re   = 1'b1;
                font_rd.addr = {code_reg, ROW_W'(0)};
            end
            ST_ROW:
            begin
                add_a      = ADD_W'(y_reg);
                add_cin    = 1'b1;
                font_rd.re = row_load;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            first_line_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:   origin_x_reg   <= cfg_data[ORG_W-1:0];
                CFG_ORIGIN_Y:   origin_y_reg   <= cfg_data[ORG_W-1:0];
                CFG_FIRST_LINE: first_line_reg <= cfg_data[LINE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Layout counters. Control bytes act in the accepting cycle; printable
    // bytes and caret finishes act in the wrap-up step after their rows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
        end
        else if (cmd_fire)
        begin
            if (cmd.mode == MODE_CHAR && cmd.char_code == CHAR_NEWLINE)
            begin
                col_reg  <= '0;
                line_reg <= line_inc;
            end
            else if (cmd.mode == MODE_CHAR && cmd.char_code == CHAR_BACKSPACE)
            begin
                if (col_reg != '0)
                begin
                    col_reg <= col_reg - 1'b1;
                end
            end
            else if (cmd.mode == MODE_FINISH && !cmd.caret_on)
            begin
                col_reg  <= '0;
                line_reg <= '0;
            end
        end
        else if (state_reg == ST_WRAP)
        begin
            if (caret_reg)
            begin
                col_reg  <= '0;
                line_reg <= '0;
            end
            else if (col_reg == COL_W'(COLUMNS - 1))
            begin
                col_reg  <= '0;
                line_reg <= line_inc;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Working registers, loaded from the shared adder step by step.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            code_reg  <= cmd.char_code;
            caret_reg <= (cmd.mode == MODE_FINISH);
        end
        unique case (state_reg)
            ST_SHOW:  diff_reg <= add_sum[DIFF_W-1:0];
            ST_XBASE: x_reg    <= add_sum[COORD_W-1:0];
            ST_XOFF:  x_reg    <= add_sum[COORD_W-1:0];
            ST_YMUL:  y_reg    <= add_sum[COORD_W-1:0];
            ST_YBASE: y_reg    <= add_sum[COORD_W-1:0];
            ST_YOFF:
            begin
                y_reg   <= add_sum[COORD_W-1:0];
                row_reg <= '0;
            end
            ST_ROW:
            begin
                if (row_load)
                begin
                    y_reg   <= add_sum[COORD_W-1:0];
                    row_reg <= row_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (row_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_load)
        begin
            out_kind_reg <= caret_reg;
            out_x_reg    <= x_reg;
            out_y_reg    <= y_reg;
            out_mask_reg <= caret_reg ? CARET_MASK : font_rdata;
            out_last_reg <= (row_reg == last_idx);
        end
    end

    assign pix.valid      = out_valid_reg;
    assign pix.row_kind   = out_kind_reg;
    assign pix.pixel_x    = out_x_reg;
    assign pix.pixel_y    = out_y_reg;
    assign pix.pixel_mask = out_mask_reg;
    assign pix.last_row   = out_last_reg;

endmodule

`default_nettype wire

### rtl/core/ttgr_checker.sv
`default_nettype none
`include "text_terminal_glyph_renderer_core_assert.svh"

module ttgr_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  logic                            cmd_ready,
    input  logic [ttgr_pkg::MODE_W-1:0]     cmd_mode,
    input  logic                            cmd_caret_on,
    input  logic                            pix_valid,
    input  logic                            pix_ready,
    input  logic                            pix_row_kind,
    input  logic [ttgr_pkg::BITS_W-1:0]     pix_pixel_mask
);
    import ttgr_pkg::*;

    // A stalled row stays offered.
    `TTGR_ASSERT_NEXT(a_pix_hold, clk, rst_n, pix_valid && !pix_ready, pix_valid)

    // Caret rows always paint the fixed caret pattern.
    `TTGR_ASSERT_IMPLY(a_caret_mask, clk, rst_n, pix_valid && pix_row_kind, pix_pixel_mask == CARET_MASK)

    // A font write completes at once.
    `TTGR_ASSERT_NEXT(a_font_write_fast, clk, rst_n, cmd_valid && cmd_ready && cmd_mode == MODE_FONT, cmd_ready)

    // A finish without caret only clears the counters and completes at once.
    `TTGR_ASSERT_NEXT(a_finish_fast, clk, rst_n, cmd_valid && cmd_ready && cmd_mode == MODE_FINISH && !cmd_caret_on, cmd_ready)

endmodule

bind text_terminal_glyph_renderer_core ttgr_checker u_ttgr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_mode       (cmd.mode),
    .cmd_caret_on   (cmd.caret_on),
    .pix_valid      (pix.valid),
    .pix_ready      (pix.ready),
    .pix_row_kind   (pix.row_kind),
    .pix_pixel_mask (pix.pixel_mask)
);

`default_nettype wire

### verif/text_terminal_glyph_renderer_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the text terminal glyph renderer.
// Terminal transactions go in on the cmd channel and pixel rows come back on
// the pix channel. Every accepted command runs through a local layout model
// that keeps its own copy of the font store, the column and line counters and
// the window registers. The model, or the hand-typed expectation of a fixed step,
// queues the pixel rows that the command must produce, and each pixel row that
// the block hands over is checked against the oldest queued row.
module text_terminal_glyph_renderer_core_tb;
    import ttgr_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_TICKS = 12;
    // This many quiet cycles after the last pixel row guarantee that the block
    // has gone idle.
    localparam int SETTLE_TICKS = 40;
    // Longest stretch without any transaction before the run is declared hung.
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_PER_PHASE = 10;
    // Every glyph that is printed costs a full set of font row writes, so the
    // number of distinct glyphs is kept small.
    localparam int MAX_GLYPHS = 3;

    // Layout geometry that the package does not name.
    localparam int CELL_W     = 8;
    localparam int LINE_PITCH = 18;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    // Mode 3 has no meaning; the block must drop it without side effects.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic ROW_GLYPH = 1'b0;
    localparam logic ROW_CARET = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FONT_AW-1:0] addr;
        logic [BITS_W-1:0]  bits;
        logic [CODE_W-1:0]  code;
        logic               caret;
    } term_cmd_t;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BITS_W-1:0]  mask;
        logic               last;
    } pix_row_t;

    // One stimulus step. When fixed is set, the row count and the position of
    // the first row are written out by hand instead of taken from the model.
    typedef struct packed {
        term_cmd_t          cmd;
        logic               fixed;
        logic [4:0]         rows;
        logic               kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ttgr_cmd_if cmd_bus ();
    ttgr_pix_if pix_bus ();

    text_terminal_glyph_renderer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .pix       (pix_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Layout model state. The window registers are only written while the
    // block is idle, so the stimulus process may update them directly.
    logic [BITS_W-1:0]  font_image [FONT_DEPTH];
    logic [COL_W-1:0]   col_pos  = '0;
    logic [LINE_W-1:0]  line_pos = '0;
    logic [ORG_W-1:0]   win_x    = '0;
    logic [ORG_W-1:0]   win_y    = '0;
    logic [LINE_W-1:0]  top_line = '0;
    pix_row_t           expected_rows [$];

    // Stimulus bookkeeping: which font entries have been written, and which
    // glyphs are complete and therefore safe to print.
    bit                 font_set [FONT_DEPTH];
    logic [CODE_W-1:0]  loaded_codes [$];
    plan_row_t          directed_plan [$];

    // Hand-typed expectation of the command currently on the bus. These are
    // updated with nonblocking assignments so that the monitor, which runs at
    // the same edge, always sees the values of the accepted command.
    logic               fixed_now  = 1'b0;
    logic [4:0]         fixed_rows = '0;
    logic               fixed_kind = 1'b0;
    logic [COORD_W-1:0] fixed_x    = '0;
    logic [COORD_W-1:0] fixed_y    = '0;

    bit calm = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [LINE_W-1:0] next_line(input logic [LINE_W-1:0] line);
        return (line == LINE_MAX) ? line : line + 1'b1;
    endfunction

    function automatic term_cmd_t make_cmd(input logic [MODE_W-1:0] mode,
                                           input logic [FONT_AW-1:0] addr,
                                           input logic [BITS_W-1:0] bits,
                                           input logic [CODE_W-1:0] code,
                                           input logic caret);
        term_cmd_t c;
        c.mode  = mode;
        c.addr  = addr;
        c.bits  = bits;
        c.code  = code;
        c.caret = caret;
        return c;
    endfunction

    // A terminal byte with the fields that it does not use left random.
    function automatic term_cmd_t byte_cmd(input logic [CODE_W-1:0] code);
        return make_cmd(MODE_CHAR, FONT_AW'($urandom), BITS_W'($urandom), code,
                        1'($urandom));
    endfunction

    function automatic term_cmd_t finish_cmd(input logic caret);
        return make_cmd(MODE_FINISH, FONT_AW'($urandom), BITS_W'($urandom),
                        CODE_W'($urandom), caret);
    endfunction

    function automatic plan_row_t open_row(input term_cmd_t c);
        plan_row_t p;
        p = '0;
        p.cmd = c;
        return p;
    endfunction

    function automatic plan_row_t fixed_row(input term_cmd_t c, input int rows,
                                            input logic kind, input int x,
                                            input int y);
        plan_row_t p;
        p.cmd   = c;
        p.fixed = 1'b1;
        p.rows  = 5'(rows);
        p.kind  = kind;
        p.x     = COORD_W'(x);
        p.y     = COORD_W'(y);
        return p;
    endfunction

    // Prefer glyphs that are already loaded so that the font traffic stays a
    // small share of the stimulus; control bytes are never returned.
    function automatic logic [CODE_W-1:0] pick_printable();
        logic [CODE_W-1:0] code;
        if (loaded_codes.size() >= MAX_GLYPHS ||
            (loaded_codes.size() > 0 && $urandom_range(0, 99) < 90))
            return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
        do
            code = CODE_W'($urandom);
        while (code == CHAR_NEWLINE || code == CHAR_BACKSPACE);
        return code;
    endfunction

    // Layout model: applies one accepted command and, when asked to, queues
    // the pixel rows that it must produce.
    task automatic predict_rows(input term_cmd_t c, input bit keep);
        int unsigned ln;
        int unsigned top;
        int unsigned cx;
        int unsigned cy;
        int r;
        bit shown;
        pix_row_t row_out;
        ln = 32'(line_pos);
        top = 32'(top_line);
        // The window bound is computed wide, so a top line near the end of
        // the counter range still shows the lines up to the saturation value.
        shown = (ln >= top) && (ln < top + VISIBLE_LINES_DEF);
        cx = 32'(win_x) + TEXT_X_OFF + 32'(col_pos) * CELL_W;
        cy = 32'(win_y) + TEXT_Y_OFF + (ln - top) * LINE_PITCH;
        case (c.mode)
            MODE_FONT:
                font_image[c.addr] = c.bits;
            MODE_CHAR:
            begin
                if (c.code == CHAR_NEWLINE)
                begin
                    col_pos = '0;
                    line_pos = next_line(line_pos);
                end
                else if (c.code == CHAR_BACKSPACE)
                begin
                    if (col_pos != '0)
                        col_pos = col_pos - 1'b1;
                end
                else
                begin
                    if (shown && keep)
                    begin
                        for (r = 0; r < GLYPH_ROWS_DEF; r++)
                        begin
                            row_out.kind = ROW_GLYPH;
                            row_out.x    = COORD_W'(cx);
                            row_out.y    = COORD_W'(cy + r);
                            row_out.mask = font_image[{c.code, ROW_W'(r)}];
                            row_out.last = (r == GLYPH_ROWS_DEF - 1);
                            expected_rows.push_back(row_out);
                        end
                    end
                    if (col_pos == COL_W'(COLUMNS_DEF - 1))
                    begin
                        col_pos = '0;
                        line_pos = next_line(line_pos);
                    end
                    else
                        col_pos = col_pos + 1'b1;
                end
            end
            MODE_FINISH:
            begin
                if (c.caret && shown && keep)
                begin
                    for (r = 0; r < CARET_ROWS; r++)
                    begin
                        row_out.kind = ROW_CARET;
                        row_out.x    = COORD_W'(cx);
                        row_out.y    = COORD_W'(cy + CARET_Y_OFF + r);
                        row_out.mask = CARET_MASK;
                        row_out.last = (r == CARET_ROWS - 1);
                        expected_rows.push_back(row_out);
                    end
                end
                col_pos = '0;
                line_pos = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: samples both channels at the clock edge, feeds accepted
    // commands to the model and checks every pixel row that is handed over.
    // It also runs the watchdog, which counts cycles without any transaction.
    always @(posedge clk)
    begin : monitor
        term_cmd_t got;
        pix_row_t want;
        int i;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                got = make_cmd(cmd_bus.mode, cmd_bus.font_address, cmd_bus.font_bits,
                               cmd_bus.char_code, cmd_bus.caret_on);
                predict_rows(got, !fixed_now);
                if (fixed_now)
                begin
                    for (i = 0; i < int'(fixed_rows); i++)
                    begin
                        want.kind = fixed_kind;
                        want.x    = fixed_x;
                        want.y    = fixed_y + COORD_W'(i);
                        want.mask = (fixed_kind == ROW_CARET) ? CARET_MASK
                                    : font_image[{got.code, ROW_W'(i)}];
                        want.last = (i == int'(fixed_rows) - 1);
                        expected_rows.push_back(want);
                    end
                end
                moved = 1'b1;
            end
            if (pix_bus.valid && pix_bus.ready)
            begin
                if (expected_rows.size() == 0)
                begin
                    $error("pixel row with nothing pending: x %0d y %0d mask %0h",
                           pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.pixel_mask);
                    mismatches++;
                end
                else
                begin
                    want = expected_rows.pop_front();
                    check_field("row_kind", 32'(want.kind), 32'(pix_bus.row_kind));
                    check_field("pixel_x", 32'(want.x), 32'(pix_bus.pixel_x));
                    check_field("pixel_y", 32'(want.y), 32'(pix_bus.pixel_y));
                    check_field("pixel_mask", 32'(want.mask), 32'(pix_bus.pixel_mask));
                    check_field("last_row", 32'(want.last), 32'(pix_bus.last_row));
                end
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d rows outstanding",
                         quiet_cycles, expected_rows.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Pixel sink: ready is high except for stalls of random length. While the
    // stimulus asks for a calm stretch, no new stall is started.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            pix_bus.ready <= 1'b0;
        end
        else
        begin
            pix_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 30)
                stall_left = pick_gap();
        end
    end

    // Drives one command and returns at the edge where it is accepted. Valid
    // stays high into the next command when there is no gap.
    task automatic send_cmd(input plan_row_t p);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.mode         <= p.cmd.mode;
        cmd_bus.font_address <= p.cmd.addr;
        cmd_bus.font_bits    <= p.cmd.bits;
        cmd_bus.char_code    <= p.cmd.code;
        cmd_bus.caret_on     <= p.cmd.caret;
        fixed_now  <= p.fixed;
        fixed_rows <= p.rows;
        fixed_kind <= p.kind;
        fixed_x    <= p.x;
        fixed_y    <= p.y;
        if (p.cmd.mode == MODE_FONT)
            font_set[p.cmd.addr] = 1'b1;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
    endtask

    // Writes any missing row of a glyph, so that no glyph row is ever read
    // from a font entry that was never written.
    task automatic ensure_glyph(input logic [CODE_W-1:0] code);
        logic [FONT_AW-1:0] addr;
        int r;
        bit fresh;
        fresh = 1'b0;
        for (r = 0; r < GLYPH_ROWS_DEF; r++)
        begin
            addr = {code, ROW_W'(r)};
            if (!font_set[addr])
            begin
                fresh = 1'b1;
                send_cmd(open_row(make_cmd(MODE_FONT, addr, BITS_W'($urandom),
                                           CODE_W'($urandom), 1'($urandom))));
            end
        end
        if (fresh)
            loaded_codes.push_back(code);
    endtask

    task automatic print_char();
        logic [CODE_W-1:0] code;
        code = pick_printable();
        ensure_glyph(code);
        send_cmd(open_row(byte_cmd(code)));
    endtask

    // Holds off the sender until every expected row has arrived, then lets
    // the block run out any command that produces no rows.
    task automatic drain_settle();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Only called while the block is idle.
    task automatic load_window(input logic [ORG_W-1:0] ox, input logic [ORG_W-1:0] oy,
                               input logic [LINE_W-1:0] first);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ORIGIN_X;
        cfg_data  <= CFG_DATA_W'(ox);
        @(posedge clk);
        cfg_index <= CFG_ORIGIN_Y;
        cfg_data  <= CFG_DATA_W'(oy);
        @(posedge clk);
        cfg_index <= CFG_FIRST_LINE;
        cfg_data  <= CFG_DATA_W'(first);
        @(posedge clk);
        cfg_we <= 1'b0;
        win_x    = ox;
        win_y    = oy;
        top_line = first;
    endtask

    initial
    begin
        plan_row_t step;
        term_cmd_t c;
        int phase;
        int done;
        int pick;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.mode         = '0;
        cmd_bus.font_address = '0;
        cmd_bus.font_bits    = '0;
        cmd_bus.char_code    = '0;
        cmd_bus.caret_on     = 1'b0;
        pix_bus.ready        = 1'b0;
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the window registers at their reset values:
        // origin 0,0 and the top line 0, so the first cell sits at x 26, y 61
        // and each line is 18 pixels further down.
        directed_plan.push_back(fixed_row(finish_cmd(1'b1), 2, ROW_CARET, 26, 75));
        directed_plan.push_back(fixed_row(finish_cmd(1'b0), 0, ROW_CARET, 0, 0));
        // Font store corners with all-ones and all-zeros row bits.
        directed_plan.push_back(fixed_row(make_cmd(MODE_FONT, '0, '1, '0, 1'b0),
                                          0, ROW_GLYPH, 0, 0));
        directed_plan.push_back(fixed_row(make_cmd(MODE_FONT, '1, '0, '1, 1'b1),
                                          0, ROW_GLYPH, 0, 0));
        directed_plan.push_back(fixed_row(byte_cmd(8'h00), 16, ROW_GLYPH, 26, 61));
        directed_plan.push_back(fixed_row(byte_cmd(8'hFF), 16, ROW_GLYPH, 34, 61));
        // Three backspaces from column two: the last one must stop at zero.
        directed_plan.push_back(fixed_row(byte_cmd(CHAR_BACKSPACE), 0, ROW_GLYPH, 0, 0));
        directed_plan.push_back(fixed_row(byte_cmd(CHAR_BACKSPACE), 0, ROW_GLYPH, 0, 0));
        directed_plan.push_back(fixed_row(byte_cmd(CHAR_BACKSPACE), 0, ROW_GLYPH, 0, 0));
        directed_plan.push_back(fixed_row(make_cmd(MODE_CHAR, '0, '0, 8'hFF, 1'b1),
                                          16, ROW_GLYPH, 26, 61));
        directed_plan.push_back(fixed_row(byte_cmd(CHAR_NEWLINE), 0, ROW_GLYPH, 0, 0));
        directed_plan.push_back(fixed_row(byte_cmd(8'h00), 16, ROW_GLYPH, 26, 79));
        // The unused mode must neither produce rows nor move the cursor, even
        // when it carries a newline code.
        directed_plan.push_back(fixed_row(make_cmd(MODE_UNUSED, FONT_AW'($urandom),
                                                   BITS_W'($urandom), CHAR_NEWLINE,
                                                   1'b1), 0, ROW_GLYPH, 0, 0));
        directed_plan.push_back(fixed_row(byte_cmd(8'hFF), 16, ROW_GLYPH, 34, 79));
        directed_plan.push_back(fixed_row(finish_cmd(1'b1), 2, ROW_CARET, 42, 93));
        // After a finish both counters are back at zero.
        directed_plan.push_back(fixed_row(finish_cmd(1'b1), 2, ROW_CARET, 26, 75));
        directed_plan.push_back(open_row(byte_cmd(8'h00)));
        directed_plan.push_back(open_row(byte_cmd(CHAR_NEWLINE)));
        directed_plan.push_back(open_row(byte_cmd(CHAR_NEWLINE)));
        directed_plan.push_back(open_row(byte_cmd(8'hFF)));
        directed_plan.push_back(open_row(finish_cmd(1'b0)));

        foreach (directed_plan[i])
        begin
            step = directed_plan[i];
            if (step.cmd.mode == MODE_CHAR && step.cmd.code != CHAR_NEWLINE
                && step.cmd.code != CHAR_BACKSPACE)
                ensure_glyph(step.cmd.code);
            send_cmd(step);
        end

        // Random phases, each with its own window. The sender waits for the
        // last pixel row and for the block to go idle before every register
        // write. Phase two runs without command gaps and starts no new pixel stall.
        for (phase = 0; phase < 4; phase++)
        begin
            drain_settle();
            case (phase)
                0: load_window('1, '1, '0);
                1: load_window('0, '0, LINE_W'(3));
                2: load_window(ORG_W'($urandom), ORG_W'($urandom),
                               LINE_W'($urandom_range(0, 8)));
                default: load_window(ORG_W'($urandom_range(0, 200)), ORG_W'(4000),
                                     LINE_W'(1));
            endcase
            calm = (phase == 2);
            if (phase == 0)
            begin
                // A full line that wraps, then down to the last shown line,
                // then one line past it where nothing may be drawn, not even
                // the caret.
                repeat (COLUMNS_DEF + 2) print_char();
                repeat (VISIBLE_LINES_DEF - 2) send_cmd(open_row(byte_cmd(CHAR_NEWLINE)));
                print_char();
                send_cmd(open_row(byte_cmd(CHAR_NEWLINE)));
                print_char();
                send_cmd(open_row(finish_cmd(1'b1)));
            end
            done = 0;
            while (done < RANDOM_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                c = byte_cmd(CODE_W'($urandom));
                if (pick < 8)
                    c.mode = MODE_FONT;
                else if (pick < 12)
                    c.mode = MODE_UNUSED;
                else if (pick < 22)
                    c.code = CHAR_NEWLINE;
                else if (pick < 29)
                    c.code = CHAR_BACKSPACE;
                else if (pick < 36)
                    c = finish_cmd($urandom_range(0, 3) != 0);
                else
                begin
                    c.code = pick_printable();
                    ensure_glyph(c.code);
                end
                send_cmd(open_row(c));
                if (c.mode != MODE_UNUSED)
                    done++;
                if ($urandom_range(0, 99) < 3)
                    drain_settle();
            end
            calm = 1'b0;
        end

        drain_settle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
